>>> rtl/md5bh_pkg.sv
`default_nettype none
package md5bh_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ADDR_W     = $clog2(BLOCK_WORDS);
  localparam int unsigned ROUNDS     = 64;
  localparam int unsigned ROUND_W    = $clog2(ROUNDS);
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [WORD_W-1:0] STD_START [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };
  localparam logic [WORD_W-1:0] PAD_FIRST  = 32'h00000080;
  localparam logic [ADDR_W-1:0] PAD_LEN_AT = ADDR_W'(14);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_USE_GIVEN = 3'd0,
    CFG_START_A   = 3'd1,
    CFG_START_B   = 3'd2,
    CFG_START_C   = 3'd3,
    CFG_START_D   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef logic [WORD_W-1:0] word_t;

  // message word index used by each round
  function automatic logic [ADDR_W-1:0] md5bh_g(input logic [ROUND_W-1:0] rnd);
    logic [ADDR_W-1:0] i;
    logic [ADDR_W-1:0] res;
    i = rnd[ADDR_W-1:0];
    unique case (rnd[ROUND_W-1:ROUND_W-2])
      2'd0: res = i;
      2'd1: res = ADDR_W'((i << 2) + i + ADDR_W'(1));
      2'd2: res = ADDR_W'((i << 1) + i + ADDR_W'(5));
      default: res = ADDR_W'((i << 3) - i);
    endcase
    return res;
  endfunction

  function automatic logic [4:0] md5bh_rot(input logic [ROUND_W-1:0] rnd);
    logic [4:0] res;
    unique case ({rnd[ROUND_W-1:ROUND_W-2], rnd[1:0]})
      4'd0:  res = 5'd7;
      4'd1:  res = 5'd12;
      4'd2:  res = 5'd17;
      4'd3:  res = 5'd22;
      4'd4:  res = 5'd5;
      4'd5:  res = 5'd9;
      4'd6:  res = 5'd14;
      4'd7:  res = 5'd20;
      4'd8:  res = 5'd4;
      4'd9:  res = 5'd11;
      4'd10: res = 5'd16;
      4'd11: res = 5'd23;
      4'd12: res = 5'd6;
      4'd13: res = 5'd10;
      4'd14: res = 5'd15;
      default: res = 5'd21;
    endcase
    return res;
  endfunction

  function automatic word_t md5bh_k(input logic [ROUND_W-1:0] rnd);
    word_t res;
    unique case (rnd)
      6'd0:  res = 32'hd76aa478;  6'd1:  res = 32'he8c7b756;
      6'd2:  res = 32'h242070db;  6'd3:  res = 32'hc1bdceee;
      6'd4:  res = 32'hf57c0faf;  6'd5:  res = 32'h4787c62a;
      6'd6:  res = 32'ha8304613;  6'd7:  res = 32'hfd469501;
      6'd8:  res = 32'h698098d8;  6'd9:  res = 32'h8b44f7af;
      6'd10: res = 32'hffff5bb1;  6'd11: res = 32'h895cd7be;
      6'd12: res = 32'h6b901122;  6'd13: res = 32'hfd987193;
      6'd14: res = 32'ha679438e;  6'd15: res = 32'h49b40821;
      6'd16: res = 32'hf61e2562;  6'd17: res = 32'hc040b340;
      6'd18: res = 32'h265e5a51;  6'd19: res = 32'he9b6c7aa;
      6'd20: res = 32'hd62f105d;  6'd21: res = 32'h02441453;
      6'd22: res = 32'hd8a1e681;  6'd23: res = 32'he7d3fbc8;
      6'd24: res = 32'h21e1cde6;  6'd25: res = 32'hc33707d6;
      6'd26: res = 32'hf4d50d87;  6'd27: res = 32'h455a14ed;
      6'd28: res = 32'ha9e3e905;  6'd29: res = 32'hfcefa3f8;
      6'd30: res = 32'h676f02d9;  6'd31: res = 32'h8d2a4c8a;
      6'd32: res = 32'hfffa3942;  6'd33: res = 32'h8771f681;
      6'd34: res = 32'h6d9d6122;  6'd35: res = 32'hfde5380c;
      6'd36: res = 32'ha4beea44;  6'd37: res = 32'h4bdecfa9;
      6'd38: res = 32'hf6bb4b60;  6'd39: res = 32'hbebfbc70;
      6'd40: res = 32'h289b7ec6;  6'd41: res = 32'heaa127fa;
      6'd42: res = 32'hd4ef3085;  6'd43: res = 32'h04881d05;
      6'd44: res = 32'hd9d4d039;  6'd45: res = 32'he6db99e5;
      6'd46: res = 32'h1fa27cf8;  6'd47: res = 32'hc4ac5665;
      6'd48: res = 32'hf4292244;  6'd49: res = 32'h432aff97;
      6'd50: res = 32'hab9423a7;  6'd51: res = 32'hfc93a039;
      6'd52: res = 32'h655b59c3;  6'd53: res = 32'h8f0ccc92;
      6'd54: res = 32'hffeff47d;  6'd55: res = 32'h85845dd1;
      6'd56: res = 32'h6fa87e4f;  6'd57: res = 32'hfe2ce6e0;
      6'd58: res = 32'ha3014314;  6'd59: res = 32'h4e0811a1;
      6'd60: res = 32'hf7537e82;  6'd61: res = 32'hbd3af235;
      6'd62: res = 32'h2ad7d2bb;  default: res = 32'heb86d391;
    endcase
    return res;
  endfunction

  function automatic word_t md5bh_swap(input word_t x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage
`default_nettype wire

>>> rtl/md5bh_ram.sv
`default_nettype none
module md5bh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> rtl/md5_block_hasher.sv
`default_nettype none
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   in_req_type, in_data_word, in_total_bytes
// out      output     out_valid/out_stall out_digest_word, out_word_index,
//                                         out_last_word, out_length_error
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// a data item is accepted in any cycle in which in_stall is low; the 16th item of a block also runs the block:
// a load state, 64 rounds at one per cycle, then an add state.
// a good finish item runs the padding block then loads four results;
// a bad finish item goes to the output state, which loads its single result once the output register is free.
// rst_n clears the control state and the config registers; cfg_ready is always high.
// in_stall is high while a block runs or results wait; out_stall holds the output register.
module md5_block_hasher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic        in_req_type,
  input  wire logic [31:0] in_data_word,
  input  wire logic [31:0] in_total_bytes,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [31:0] out_digest_word,
  output      logic [1:0]  out_word_index,
  output      logic        out_last_word,
  output      logic        out_length_error,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned AW = md5bh_pkg::ADDR_W;
  localparam int unsigned RW = md5bh_pkg::ROUND_W;

  md5bh_pkg::state_t state_r, state_nxt;
  logic [RW-1:0]     round_r, round_nxt;
  logic [AW-1:0]     fill_r, fill_nxt;
  logic              run_active_r, run_active_nxt;
  logic              pad_mode_r, pad_mode_nxt;
  logic              err_r, err_nxt;
  logic [1:0]        out_cnt_r, out_cnt_nxt;
  md5bh_pkg::word_t  bitcnt_r, bitcnt_nxt;
  md5bh_pkg::word_t  chain_r [4];
  md5bh_pkg::word_t  chain_nxt [4];
  md5bh_pkg::word_t  work_r [4];
  md5bh_pkg::word_t  work_nxt [4];

  logic              use_given_r;
  md5bh_pkg::word_t  start_r [4];

  logic              out_valid_r, out_valid_nxt;
  md5bh_pkg::word_t  out_digest_r, out_digest_nxt;
  logic [1:0]        out_idx_r, out_idx_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_err_r, out_err_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  md5bh_pkg::word_t  ram_rdata;

  logic              in_acc;
  logic [AW-1:0]     g_cur;
  md5bh_pkg::word_t  msg_word;
  md5bh_pkg::word_t  f_val;
  md5bh_pkg::word_t  sum_val;
  logic [63:0]       rot_dbl;

  md5bh_ram #(
    .WIDTH(md5bh_pkg::WORD_W),
    .DEPTH(md5bh_pkg::BLOCK_WORDS)
  ) u_words (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(in_data_word),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  assign cfg_ready        = 1'b1;
  assign in_stall         = (state_r != md5bh_pkg::ST_IDLE);
  assign in_acc           = in_valid && !in_stall;
  assign out_valid        = out_valid_r;
  assign out_digest_word  = out_digest_r;
  assign out_word_index   = out_idx_r;
  assign out_last_word    = out_last_r;
  assign out_length_error = out_err_r;

  // round datapath
  always_comb begin
    g_cur = md5bh_pkg::md5bh_g(round_r);
    if (pad_mode_r) begin
      if (g_cur == '0) begin
        msg_word = md5bh_pkg::PAD_FIRST;
      end else if (g_cur == md5bh_pkg::PAD_LEN_AT) begin
        msg_word = bitcnt_r;
      end else begin
        msg_word = '0;
      end
    end else begin
      msg_word = ram_rdata;
    end
    unique case (round_r[RW-1:RW-2])
      2'd0: f_val = work_r[3] ^ (work_r[1] & (work_r[2] ^ work_r[3]));
      2'd1: f_val = work_r[2] ^ (work_r[3] & (work_r[1] ^ work_r[2]));
      2'd2: f_val = work_r[1] ^ work_r[2] ^ work_r[3];
      default: f_val = work_r[2] ^ (work_r[1] | ~work_r[3]);
    endcase
    sum_val = work_r[0] + f_val + md5bh_pkg::md5bh_k(round_r) + msg_word;
    rot_dbl = {sum_val, sum_val} << md5bh_pkg::md5bh_rot(round_r);
  end

  always_comb begin
    state_nxt      = state_r;
    round_nxt      = round_r;
    fill_nxt       = fill_r;
    run_active_nxt = run_active_r;
    pad_mode_nxt   = pad_mode_r;
    err_nxt        = err_r;
    out_cnt_nxt    = out_cnt_r;
    bitcnt_nxt     = bitcnt_r;
    chain_nxt      = chain_r;
    work_nxt       = work_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_digest_nxt = out_digest_r;
    out_idx_nxt    = out_idx_r;
    out_last_nxt   = out_last_r;
    out_err_nxt    = out_err_r;
    ram_we         = 1'b0;
    ram_waddr      = fill_r;
    // prefetch the word for the next round
    ram_raddr      = (state_r == md5bh_pkg::ST_ROUND) ?
                     md5bh_pkg::md5bh_g(RW'(round_r + RW'(1))) : '0;

    unique case (state_r)
      md5bh_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!run_active_r) begin
            for (int i = 0; i < 4; i++) begin
              chain_nxt[i] = use_given_r ? start_r[i] : md5bh_pkg::STD_START[i];
            end
          end
          run_active_nxt = 1'b1;
          if (!in_req_type) begin
            ram_we   = 1'b1;
            fill_nxt = AW'(fill_r + AW'(1));
            if (fill_r == AW'(md5bh_pkg::BLOCK_WORDS - 1)) begin
              pad_mode_nxt = 1'b0;
              state_nxt    = md5bh_pkg::ST_LOAD;
            end
          end else begin
            run_active_nxt = 1'b0;
            fill_nxt       = '0;
            out_cnt_nxt    = '0;
            if (in_total_bytes[5:0] != 6'd0 || fill_r != '0) begin
              err_nxt   = 1'b1;
              state_nxt = md5bh_pkg::ST_OUT;
            end else begin
              err_nxt      = 1'b0;
              pad_mode_nxt = 1'b1;
              bitcnt_nxt   = {in_total_bytes[28:0], 3'b000};
              state_nxt    = md5bh_pkg::ST_LOAD;
            end
          end
        end
      end
      md5bh_pkg::ST_LOAD: begin
        work_nxt  = chain_r;
        round_nxt = '0;
        state_nxt = md5bh_pkg::ST_ROUND;
      end
      md5bh_pkg::ST_ROUND: begin
        work_nxt[0] = work_r[3];
        work_nxt[1] = work_r[1] + rot_dbl[63:32];
        work_nxt[2] = work_r[1];
        work_nxt[3] = work_r[2];
        round_nxt   = RW'(round_r + RW'(1));
        if (round_r == RW'(md5bh_pkg::ROUNDS - 1)) begin
          state_nxt = md5bh_pkg::ST_ADD;
        end
      end
      md5bh_pkg::ST_ADD: begin
        for (int i = 0; i < 4; i++) begin
          chain_nxt[i] = chain_r[i] + work_r[i];
        end
        state_nxt = pad_mode_r ? md5bh_pkg::ST_OUT : md5bh_pkg::ST_IDLE;
      end
      md5bh_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (err_r) begin
            out_digest_nxt = '0;
            out_idx_nxt    = '0;
            out_last_nxt   = 1'b1;
            out_err_nxt    = 1'b1;
            state_nxt      = md5bh_pkg::ST_IDLE;
          end else begin
            out_digest_nxt = md5bh_pkg::md5bh_swap(chain_r[out_cnt_r]);
            out_idx_nxt    = out_cnt_r;
            out_last_nxt   = (out_cnt_r == 2'd3);
            out_err_nxt    = 1'b0;
            out_cnt_nxt    = out_cnt_r + 2'd1;
            if (out_cnt_r == 2'd3) begin
              state_nxt = md5bh_pkg::ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = md5bh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= md5bh_pkg::ST_IDLE;
      round_r      <= '0;
      fill_r       <= '0;
      run_active_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      round_r      <= round_nxt;
      fill_r       <= fill_nxt;
      run_active_r <= run_active_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pad_mode_r   <= pad_mode_nxt;
    err_r        <= err_nxt;
    out_cnt_r    <= out_cnt_nxt;
    bitcnt_r     <= bitcnt_nxt;
    chain_r      <= chain_nxt;
    work_r       <= work_nxt;
    out_digest_r <= out_digest_nxt;
    out_idx_r    <= out_idx_nxt;
    out_last_r   <= out_last_nxt;
    out_err_r    <= out_err_nxt;
  end

  // config registers, index beyond the list is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_given_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        start_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        md5bh_pkg::CFG_USE_GIVEN: use_given_r <= cfg_data[0];
        md5bh_pkg::CFG_START_A:   start_r[0]  <= cfg_data;
        md5bh_pkg::CFG_START_B:   start_r[1]  <= cfg_data;
        md5bh_pkg::CFG_START_C:   start_r[2]  <= cfg_data;
        md5bh_pkg::CFG_START_D:   start_r[3]  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> verif/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic REQ_DATA   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  localparam int SETTLE_CYCLES    = 80;   // one block run plus margin
  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int HOLD_AFTER_ITEMS = 50;
  localparam int HOLD_CYCLES      = 600;
  localparam int PHASE_ITEMS      = 48;
  localparam int MAX_REPORTS      = 40;

  localparam md5bh_pkg::word_t MD5_IV [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam md5bh_pkg::word_t SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int SHIFT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  typedef struct packed {
    logic             req;
    md5bh_pkg::word_t word;
    md5bh_pkg::word_t total;
  } msg_item_t;

  typedef struct packed {
    md5bh_pkg::word_t digest;
    logic [1:0]       idx;
    logic             last;
    logic             err;
  } digest_res_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_req_type = REQ_DATA;
  md5bh_pkg::word_t     in_data_word = '0;
  md5bh_pkg::word_t     in_total_bytes = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  md5bh_pkg::word_t     out_digest_word;
  logic [1:0]           out_word_index;
  logic                 out_last_word;
  logic                 out_length_error;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  md5bh_pkg::cfg_idx_t  cfg_index = md5bh_pkg::CFG_USE_GIVEN;
  md5bh_pkg::word_t     cfg_data = '0;

  md5_block_hasher dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_data_word     (in_data_word),
    .in_total_bytes   (in_total_bytes),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_digest_word  (out_digest_word),
    .out_word_index   (out_word_index),
    .out_last_word    (out_last_word),
    .out_length_error (out_length_error),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // hash state mirrored from the block
  logic              start_from_cfg = 1'b0;
  md5bh_pkg::word_t  cfg_start [4] = '{default: '0};
  md5bh_pkg::word_t  chain_q [4];
  md5bh_pkg::word_t  blk_q [16];
  logic [3:0]        fill_q = '0;
  bit                run_open = 1'b0;

  msg_item_t   msg_items [$];
  digest_res_t digest_due [$];

  bit in_took = 1'b0;
  bit out_took = 1'b0;
  bit hold_done = 1'b0;
  int in_gap = 0;
  int stall_left = 0;
  int items_sent = 0;
  int items_in = 0;
  int items_pushed = 0;
  int results_seen = 0;
  int runs_done = 0;
  int len_errors = 0;
  int settings_used = 0;
  int err_count = 0;
  int quiet_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic md5bh_pkg::word_t rotl(input md5bh_pkg::word_t x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic void absorb_block(input md5bh_pkg::word_t m [16]);
    md5bh_pkg::word_t a, b, c, d, f, t;
    int g;
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = d ^ (b & (c ^ d));
          g = i;
        end
        1: begin
          f = c ^ (d & (b ^ c));
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      t = a + f + SINE_K[i] + m[g];
      a = d;
      d = c;
      c = b;
      b = b + rotl(t, SHIFT_AMT[(i / 16) * 4 + i % 4]);
    end
    chain_q[0] += a;
    chain_q[1] += b;
    chain_q[2] += c;
    chain_q[3] += d;
  endfunction

  // works out the results of one accepted item and queues them
  function automatic void hash_item(input msg_item_t it);
    md5bh_pkg::word_t pad [16];
    md5bh_pkg::word_t w;
    if (!run_open) begin
      for (int i = 0; i < 4; i++) chain_q[i] = start_from_cfg ? cfg_start[i] : MD5_IV[i];
      fill_q = '0;
      run_open = 1'b1;
    end
    if (it.req == REQ_DATA) begin
      blk_q[fill_q] = it.word;
      fill_q = fill_q + 4'd1;
      if (fill_q == 4'd0) absorb_block(blk_q);
      return;
    end
    run_open = 1'b0;
    runs_done++;
    if (it.total[5:0] != 6'd0 || fill_q != 4'd0) begin
      fill_q = '0;
      len_errors++;
      digest_due.push_back('{digest: '0, idx: 2'd0, last: 1'b1, err: 1'b1});
      return;
    end
    pad = '{default: '0};
    pad[0] = 32'h00000080;
    pad[14] = it.total << 3;
    absorb_block(pad);
    for (int i = 0; i < 4; i++) begin
      w = chain_q[i];
      digest_due.push_back('{digest: {w[7:0], w[15:8], w[23:16], w[31:24]},
                             idx: 2'(i), last: (i == 3), err: 1'b0});
    end
  endfunction

  // bursts with no idling every third stretch of 24
  function automatic int pick_gap(input int n);
    if ((n / 24) % 3 == 2) return 0;
    return $urandom_range(0, 13);
  endfunction

  task automatic flag_mismatch(input string what, input digest_res_t got,
                               input digest_res_t want);
    if (err_count < MAX_REPORTS)
      $display("[%0t] %s: got %h/%0d/%b/%b want %h/%0d/%b/%b", $realtime, what,
               got.digest, got.idx, got.last, got.err,
               want.digest, want.idx, want.last, want.err);
    err_count++;
  endtask

  // driver: offers pending items at the falling edge
  always @(negedge clk) begin
    msg_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold the stalled item
    end else if (in_gap > 0) begin
      in_gap--;
      in_valid <= 1'b0;
    end else if (msg_items.size() != 0) begin
      nxt = msg_items.pop_front();
      in_valid <= 1'b1;
      in_req_type <= nxt.req;
      in_data_word <= nxt.word;
      in_total_bytes <= nxt.total;
      in_gap = pick_gap(items_sent);
      items_sent++;
    end else begin
      in_valid <= 1'b0;
    end
    in_took = 1'b0;
  end

  // receiver: per-result stalls and one long hold-off
  always @(negedge clk) begin
    if (out_took) stall_left = pick_gap(results_seen);
    if (!hold_done && items_in >= HOLD_AFTER_ITEMS) begin
      stall_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
    out_took = 1'b0;
  end

  // monitor: predicts on accepted items, checks accepted results
  always @(posedge clk) begin
    digest_res_t got, want;
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        hash_item('{req: in_req_type, word: in_data_word, total: in_total_bytes});
        items_in++;
        in_took = 1'b1;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        got = {out_digest_word, out_word_index, out_last_word, out_length_error};
        if (digest_due.size() == 0) begin
          flag_mismatch("result with nothing expected", got, '0);
        end else begin
          want = digest_due.pop_front();
          if (got.digest !== want.digest || got.idx !== want.idx ||
              got.last !== want.last || got.err !== want.err)
            flag_mismatch("result mismatch", got, want);
        end
        results_seen++;
        out_took = 1'b1;
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready) moved = 1'b1;
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, digest_due.size());
        $display("md5_block_hasher regression: fail");
        $finish;
      end
    end
  end

  task automatic push_data(input md5bh_pkg::word_t w);
    msg_items.push_back('{req: REQ_DATA, word: w, total: $urandom});
    items_pushed++;
  endtask

  task automatic push_finish(input md5bh_pkg::word_t total);
    msg_items.push_back('{req: REQ_FINISH, word: $urandom, total: total});
    items_pushed++;
  endtask

  task automatic cfg_write(input md5bh_pkg::cfg_idx_t idx, input md5bh_pkg::word_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      md5bh_pkg::CFG_USE_GIVEN: start_from_cfg = val[0];
      md5bh_pkg::CFG_START_A:   cfg_start[0] = val;
      md5bh_pkg::CFG_START_B:   cfg_start[1] = val;
      md5bh_pkg::CFG_START_C:   cfg_start[2] = val;
      md5bh_pkg::CFG_START_D:   cfg_start[3] = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_config(input logic use_given, input md5bh_pkg::word_t a,
                             input md5bh_pkg::word_t b, input md5bh_pkg::word_t c,
                             input md5bh_pkg::word_t d);
    cfg_write(md5bh_pkg::CFG_USE_GIVEN, {31'b0, use_given});
    cfg_write(md5bh_pkg::CFG_START_A, a);
    cfg_write(md5bh_pkg::CFG_START_B, b);
    cfg_write(md5bh_pkg::CFG_START_C, c);
    cfg_write(md5bh_pkg::CFG_START_D, d);
    settings_used++;
    @(posedge clk);
  endtask

  // all items taken, all results back, then let a block run finish
  task automatic wait_drained();
    while (msg_items.size() != 0 || in_valid || digest_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_run();
    int kind, nblk, extra;
    md5bh_pkg::word_t total;
    kind = $urandom_range(0, 9);
    case ($urandom_range(0, 19))
      0:       nblk = 3;
      1, 2:    nblk = 2;
      default: nblk = $urandom_range(0, 1);
    endcase
    extra = 0;
    total = 32'(nblk * 64);
    if (kind < 2) extra = $urandom_range(1, 15);             // partly filled block
    else if (kind == 2) total = $urandom;                    // arbitrary length
    else if (kind < 5) total = $urandom & 32'hffffffc0;      // good length, any size
    repeat (nblk * 16 + extra) push_data($urandom);
    push_finish(total);
  endtask

  task automatic random_phase();
    int first;
    first = items_pushed;
    // finishing straight from the start words
    push_finish($urandom & 32'hffffffc0);
    while (items_pushed - first < PHASE_ITEMS) random_run();
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    load_config(1'b0, '0, '0, '0, '0);

    // empty message
    push_finish(32'd0);
    // one block of edge-value words
    push_data(32'h00000000);
    push_data(32'hffffffff);
    push_data(32'haaaaaaaa);
    push_data(32'h55555555);
    push_data(32'h80000000);
    push_data(32'h00000001);
    repeat (10) push_data($urandom);
    push_finish(32'd64);
    // largest good length, bit count wraps
    push_finish(32'hffffffc0);
    // length not a multiple of 64
    push_finish(32'hffffffff);
    // partly filled block
    repeat (3) push_data($urandom);
    push_finish(32'd64);
    wait_drained();

    load_config(1'b1, '1, '1, '1, '1);
    random_phase();
    load_config(1'b1, '0, '0, '0, '0);
    random_phase();
    load_config(1'b0, $urandom, $urandom, $urandom, $urandom);
    random_phase();
    load_config(1'b1, $urandom, $urandom, $urandom, $urandom);
    random_phase();
    load_config(1'b0, $urandom, $urandom, $urandom, $urandom);
    random_phase();

    $display("sent %0d items in %0d finished runs, %0d of them with bad lengths",
             items_in, runs_done, len_errors);
    $display("checked %0d results across %0d start settings, %0d mismatches",
             results_seen, settings_used, err_count);
    if (err_count == 0) begin
      $display("md5_block_hasher regression: pass");
    end else begin
      $display("md5_block_hasher regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
rtl/md5bh_pkg.sv
rtl/md5bh_ram.sv
rtl/md5_block_hasher.sv
verif/testbench.sv
